// File: rtl/qn_pkg.sv
// quaternion normalise package: default widths shared by the block and its checker
// no dependencies
package qn_pkg;
   localparam int DEF_COMP_WIDTH = 16;
   localparam int DEF_FRAC_BITS  = 12;
endpackage

// File: rtl/qn_sqrt_cell.sv
// one bit of the integer square root chain: tries one root bit, passes the word on
// depends on qn_pkg
module qn_sqrt_cell #(
   parameter int SW  = 34,
   parameter int RB  = 17,
   parameter int BIT = 0,
   parameter int PW  = 1
) (
   input  logic          clock,
   input  logic [SW-1:0] prev_s,
   input  logic [SW-1:0] prev_sq,
   input  logic [RB-1:0] prev_root,
   input  logic [PW-1:0] prev_pass,
   output logic [SW-1:0] next_s,
   output logic [SW-1:0] next_sq,
   output logic [RB-1:0] next_root,
   output logic [PW-1:0] next_pass
);
   import qn_pkg::*;

   logic [SW-1:0] cand_sq;
   logic [SW-1:0] s_ff, sq_ff, sq_in;
   logic [RB-1:0] root_ff, root_in;
   logic [PW-1:0] pass_ff;

   // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
   assign cand_sq = prev_sq + (SW'(prev_root) << (BIT + 1)) + (SW'(1) << (2 * BIT));

   always_comb begin
      sq_in   = prev_sq;
      root_in = prev_root;
      if (cand_sq <= prev_s) begin
         sq_in   = cand_sq;
         root_in = prev_root | (RB'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= prev_s;
      sq_ff   <= sq_in;
      root_ff <= root_in;
      pass_ff <= prev_pass;
   end

   assign next_s    = s_ff;
   assign next_sq   = sq_ff;
   assign next_root = root_ff;
   assign next_pass = pass_ff;
endmodule

// File: rtl/qn_div_cell.sv
// one quotient bit of a restoring divide chain for one component lane
// depends on qn_pkg
module qn_div_cell #(
   parameter int DW = 30,
   parameter int RB = 17,
   parameter int QW = 13,
   parameter int K  = 0,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic [DW-1:0] prev_rem,
   input  logic [RB-1:0] prev_dvs,
   input  logic [QW-1:0] prev_q,
   input  logic [PW-1:0] prev_pass,
   output logic [DW-1:0] next_rem,
   output logic [RB-1:0] next_dvs,
   output logic [QW-1:0] next_q,
   output logic [PW-1:0] next_pass
);
   import qn_pkg::*;

   logic [DW-1:0] trial;
   logic [DW-1:0] rem_ff, rem_in;
   logic [RB-1:0] dvs_ff;
   logic [QW-1:0] q_ff, q_in;
   logic [PW-1:0] pass_ff;

   assign trial = DW'(prev_dvs) << K;

   always_comb begin
      rem_in = prev_rem;
      q_in   = prev_q;
      if (prev_rem >= trial) begin
         rem_in = prev_rem - trial;
         q_in   = prev_q | (QW'(1) << K);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dvs_ff  <= prev_dvs;
      q_ff    <= q_in;
      pass_ff <= prev_pass;
   end

   assign next_rem  = rem_ff;
   assign next_dvs  = dvs_ff;
   assign next_q    = q_ff;
   assign next_pass = pass_ff;
endmodule

// File: rtl/quaternion_normalise.sv
// quaternion normalise: scales (x, y, z, w) to unit length in fixed point
// depends on qn_pkg, qn_sqrt_cell, qn_div_cell
//
// usage: drive the four components on req_comp_* and raise start; a word is
// taken at every rising edge with start high, since busy never rises. one
// word may enter each cycle.
// each result shows on rsp_* for one cycle with rsp_valid high. its path
// is set by the cell chains: registers to take magnitudes, square and sum,
// one square root cell per root bit (COMP_WIDTH + 1), one divide cell per
// quotient bit (FRAC_BITS + 1) in four parallel lanes, and one output
// register.
// an all-zero input gives (0, 0, 0, 1.0) with rsp_was_zero high.
// reset clears the valid pipeline; words in flight are dropped.
// the receiver cannot stall; results are delivered unconditionally.
module quaternion_normalise #(
   parameter int COMP_WIDTH = qn_pkg::DEF_COMP_WIDTH,
   parameter int FRAC_BITS  = qn_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COMP_WIDTH-1:0] req_comp_x,
   input  logic signed [COMP_WIDTH-1:0] req_comp_y,
   input  logic signed [COMP_WIDTH-1:0] req_comp_z,
   input  logic signed [COMP_WIDTH-1:0] req_comp_w,
   output logic                         rsp_valid,
   output logic signed [FRAC_BITS+1:0]  rsp_unit_x,
   output logic signed [FRAC_BITS+1:0]  rsp_unit_y,
   output logic signed [FRAC_BITS+1:0]  rsp_unit_z,
   output logic signed [FRAC_BITS+1:0]  rsp_unit_w,
   output logic                         rsp_was_zero
);
   import qn_pkg::*;

   localparam int W   = COMP_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int SW  = 2 * W + 2;
   localparam int RB  = W + 1;
   localparam int QW  = F + 1;
   localparam int OW  = F + 2;
   localparam int DW  = W + F + 2;
   localparam int SPW = 4 * W + 4;
   localparam int LAT = 3 + RB + QW + 1;

   logic [LAT-1:0] valid_ff;

   logic [W-1:0]  raw [4];
   logic [W-1:0]  mag_ff [4];
   logic [3:0]    neg_ff, neg_sq_ff, neg_sum_ff;
   logic [W-1:0]  mag_sq_ff [4];
   logic [W-1:0]  mag_sum_ff [4];
   logic [SW-1:0] sqr_ff [4];
   logic [SW-1:0] sum_ff;

   logic [SW-1:0]  s_w    [RB+1];
   logic [SW-1:0]  sq_w   [RB+1];
   logic [RB-1:0]  root_w [RB+1];
   logic [SPW-1:0] spass_w[RB+1];

   logic [DW-1:0] rem_w  [4][QW+1];
   logic [RB-1:0] dvs_w  [4][QW+1];
   logic [QW-1:0] q_w    [4][QW+1];
   logic [1:0]    dpass_w[4][QW+1];

   logic [OW-1:0] unit_ff [4];
   logic          zero_ff;

   assign busy   = 1'b0;
   assign raw[0] = req_comp_x;
   assign raw[1] = req_comp_y;
   assign raw[2] = req_comp_z;
   assign raw[3] = req_comp_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LAT-2:0], start};
      end
   end

   // magnitudes, squares and sum; the most negative value maps to 2^(W-1)
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         neg_ff[i]     <= raw[i][W-1];
         mag_ff[i]     <= raw[i][W-1] ? (~raw[i] + W'(1)) : raw[i];
         sqr_ff[i]     <= SW'(mag_ff[i]) * SW'(mag_ff[i]);
         mag_sq_ff[i]  <= mag_ff[i];
         mag_sum_ff[i] <= mag_sq_ff[i];
      end
      neg_sq_ff  <= neg_ff;
      neg_sum_ff <= neg_sq_ff;
      sum_ff     <= sqr_ff[0] + sqr_ff[1] + sqr_ff[2] + sqr_ff[3];
   end

   assign s_w[0]     = sum_ff;
   assign sq_w[0]    = '0;
   assign root_w[0]  = '0;
   assign spass_w[0] = {neg_sum_ff, mag_sum_ff[3], mag_sum_ff[2], mag_sum_ff[1],
                        mag_sum_ff[0]};

   for (genvar i = 0; i < RB; i++) begin : g_sqrt
      qn_sqrt_cell #(.SW(SW), .RB(RB), .BIT(RB - 1 - i), .PW(SPW)) u_cell (
         .clock     (clock),
         .prev_s    (s_w[i]),
         .prev_sq   (sq_w[i]),
         .prev_root (root_w[i]),
         .prev_pass (spass_w[i]),
         .next_s    (s_w[i+1]),
         .next_sq   (sq_w[i+1]),
         .next_root (root_w[i+1]),
         .next_pass (spass_w[i+1])
      );
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      // pass word per lane: {zero length, sign}
      assign rem_w[l][0]   = DW'(spass_w[RB][l*W +: W]) << F;
      assign dvs_w[l][0]   = root_w[RB];
      assign q_w[l][0]     = '0;
      assign dpass_w[l][0] = {(s_w[RB] == '0), spass_w[RB][4*W + l]};
      for (genvar j = 0; j < QW; j++) begin : g_div
         qn_div_cell #(.DW(DW), .RB(RB), .QW(QW), .K(F - j), .PW(2)) u_cell (
            .clock     (clock),
            .prev_rem  (rem_w[l][j]),
            .prev_dvs  (dvs_w[l][j]),
            .prev_q    (q_w[l][j]),
            .prev_pass (dpass_w[l][j]),
            .next_rem  (rem_w[l][j+1]),
            .next_dvs  (dvs_w[l][j+1]),
            .next_q    (q_w[l][j+1]),
            .next_pass (dpass_w[l][j+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= dpass_w[0][QW][1];
      for (int i = 0; i < 4; i++) begin
         if (dpass_w[0][QW][1]) begin
            unit_ff[i] <= (i == 3) ? (OW'(1) << F) : '0;
         end else if (dpass_w[i][QW][0]) begin
            unit_ff[i] <= ~OW'(q_w[i][QW]) + OW'(1);
         end else begin
            unit_ff[i] <= OW'(q_w[i][QW]);
         end
      end
   end

   assign rsp_valid    = valid_ff[LAT-1];
   assign rsp_unit_x   = unit_ff[0];
   assign rsp_unit_y   = unit_ff[1];
   assign rsp_unit_z   = unit_ff[2];
   assign rsp_unit_w   = unit_ff[3];
   assign rsp_was_zero = zero_ff;
endmodule

// File: rtl/qn_check.sv
// port checker for quaternion_normalise, attached by bind
// depends on qn_pkg
module qn_check #(
   parameter int COMP_WIDTH = qn_pkg::DEF_COMP_WIDTH,
   parameter int FRAC_BITS  = qn_pkg::DEF_FRAC_BITS
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic signed [COMP_WIDTH-1:0] req_comp_x,
   input logic signed [COMP_WIDTH-1:0] req_comp_y,
   input logic signed [COMP_WIDTH-1:0] req_comp_z,
   input logic signed [COMP_WIDTH-1:0] req_comp_w,
   input logic                         rsp_valid,
   input logic signed [FRAC_BITS+1:0]  rsp_unit_x,
   input logic signed [FRAC_BITS+1:0]  rsp_unit_y,
   input logic signed [FRAC_BITS+1:0]  rsp_unit_z,
   input logic signed [FRAC_BITS+1:0]  rsp_unit_w,
   input logic                         rsp_was_zero
);
   import qn_pkg::*;

   localparam int LAT = COMP_WIDTH + FRAC_BITS + 6;
   localparam int OW  = FRAC_BITS + 2;
   localparam logic signed [OW-1:0] ONE  = OW'(1) << FRAC_BITS;
   localparam logic signed [OW-1:0] MONE = -(OW'(1) << FRAC_BITS);

   // every accepted word yields a result a fixed time later
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid) else $error("result missing");

   // zero input travels through the whole chain and yields zero length
   a_zero_path: assert property (@(posedge clock) disable iff (reset)
      (start && req_comp_x == '0 && req_comp_y == '0 && req_comp_z == '0
       && req_comp_w == '0) |-> ##LAT (rsp_valid && rsp_was_zero))
      else $error("zero input not flagged");

   a_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_zero) |-> (rsp_unit_x == '0 && rsp_unit_y == '0
       && rsp_unit_z == '0 && rsp_unit_w == ONE)) else $error("bad identity");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_x <= ONE && rsp_unit_x >= MONE
       && rsp_unit_y <= ONE && rsp_unit_y >= MONE
       && rsp_unit_z <= ONE && rsp_unit_z >= MONE
       && rsp_unit_w <= ONE && rsp_unit_w >= MONE)) else $error("unit out of range");

   a_no_busy: assert property (@(posedge clock) !busy) else $error("busy raised");
endmodule

bind quaternion_normalise qn_check #(
   .COMP_WIDTH (COMP_WIDTH),
   .FRAC_BITS  (FRAC_BITS)
) u_qn_check (.*);
